@@ hdl/olisd_pkg.sv @@
// Package for the ordered list unit: sizes, operation and status codes,
// request/result structs and sequencer states. No dependencies.
`timescale 1ns / 1ps

package olisd_pkg;

  localparam int DEPTH = 16;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_DELETE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [4:0] position;
    logic [4:0] count;
  } res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

@@ hdl/olisd_ram.sv @@
// Entry store for the ordered list: one write port, one read port with
// registered read data. Depends on olisd_pkg.
`timescale 1ns / 1ps

module olisd_ram
  import olisd_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [IW-1:0]     waddr,
  input  logic signed [31:0] wdata,
  input  logic              re,
  input  logic [IW-1:0]     raddr,
  output logic signed [31:0] rdata
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/ordered_list_insert_search_delete_unit.sv @@
// Ordered list unit: append, search and delete-first-match over a bounded list.
// The single memory read port walks one entry per cycle for compare, then again for the shift.
// One request in flight; the next is accepted once the sequencer is back in idle, later while out_stall holds a result.
// Reset (sync, rst_n low) empties the list and drops out_valid; entries are not cleared.
// Depends on olisd_pkg and olisd_ram.
`timescale 1ns / 1ps

module ordered_list_insert_search_delete_unit
  import olisd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data
);

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          cmp_v_r, cmp_v_nxt;
  logic [IW-1:0] cmp_idx_r, cmp_idx_nxt;
  req_t          req_r, req_nxt;
  res_t          res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  res_t          out_data_r, out_data_nxt;

  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               mem_re;
  logic [IW-1:0]      mem_raddr;
  logic signed [31:0] mem_rdata;
  logic               issue;

  olisd_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign issue     = (ptr_r < count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cmp_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_v_r     <= cmp_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    cmp_v_nxt     = 1'b0;
    cmp_idx_nxt   = ptr_r[IW-1:0];
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = cmp_idx_r;
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = ptr_r[IW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt          = in_data;
          res_nxt.status   = ST_OK;
          res_nxt.found    = 1'b0;
          res_nxt.position = '0;
          res_nxt.count    = 5'(count_r);
          ptr_nxt          = '0;
          state_nxt        = S_DONE;
          unique case (in_data.func)
            FUNC_APPEND: begin
              if (count_r == CW'(DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = count_r[IW-1:0];
                mem_wdata     = in_data.value;
                count_nxt     = count_r + CW'(1);
                res_nxt.count = 5'(count_r + CW'(1));
              end
            end
            FUNC_SEARCH, FUNC_DELETE: begin
              state_nxt = S_SCAN;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (issue) begin
          mem_re    = 1'b1;
          ptr_nxt   = ptr_r + CW'(1);
          cmp_v_nxt = 1'b1;
        end
        priority if (cmp_v_r && (mem_rdata == req_r.value)) begin
          res_nxt.found    = 1'b1;
          res_nxt.position = 5'(cmp_idx_r) + 5'd1;
          cmp_v_nxt        = 1'b0;
          mem_re           = 1'b0;
          if (req_r.func == FUNC_DELETE) begin
            ptr_nxt   = CW'(cmp_idx_r) + CW'(1);
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (!cmp_v_r && !issue) begin
          res_nxt.status = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SHIFT: begin
        // read entry k, write it back at k-1 in the next cycle
        if (issue) begin
          mem_re    = 1'b1;
          ptr_nxt   = ptr_r + CW'(1);
          cmp_v_nxt = 1'b1;
        end
        if (cmp_v_r) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_idx_r - IW'(1);
          mem_wdata = mem_rdata;
        end
        if (!issue && !cmp_v_r) begin
          count_nxt     = count_r - CW'(1);
          res_nxt.count = 5'(count_r - CW'(1));
          state_nxt     = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("request accepted but sequencer idle");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (count_r != '0))
    else $error("shift on empty list");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.found) |-> (out_data_r.status == ST_OK &&
                                           out_data_r.position != 5'd0))
    else $error("found result with bad status or position");

endmodule
